>>> rtl/core/tcmma_pkg.sv
// shared constants and types for the three channel min/max moving average block
// no dependencies
`default_nettype none

package tcmma_pkg;

	localparam int DATA_W     = 16;
	localparam int CHANNELS   = 3;
	localparam int WINDOW_DEF = 8;
	localparam int IN_W       = CHANNELS * DATA_W;
	localparam int OUT_W      = 3 * CHANNELS * DATA_W;

	typedef struct packed {
		logic accept;
		logic advance;
		logic first;
		logic old_valid;
	} chan_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/tcmma_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module tcmma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tcmma_channel.sv
// one channel: sample register, history ring, running sum, running min and max
// depends on tcmma_pkg and tcmma_ram
`default_nettype none

module tcmma_channel
	import tcmma_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire chan_ctl_t                 ctl,
	input  wire logic [$clog2(WINDOW)-1:0] rd_addr,
	input  wire logic [$clog2(WINDOW)-1:0] wr_addr,
	input  wire logic signed [DATA_W-1:0]  sample_in,
	output logic signed      [DATA_W-1:0]  min_next,
	output logic signed      [DATA_W-1:0]  max_next,
	output logic signed      [DATA_W-1:0]  avg_next
);

	localparam int L  = $clog2(WINDOW);
	localparam int SW = DATA_W + L;
	localparam int K  = SW + L;
	localparam logic [63:0] RECIP64 = ((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [SW:0] RECIP = RECIP64[SW:0];

	logic signed [DATA_W-1:0] sample_s1;
	logic signed [DATA_W-1:0] low_q;
	logic signed [DATA_W-1:0] high_q;
	logic signed [SW-1:0]     sum_q;
	logic        [DATA_W-1:0] rd_data;
	logic signed [DATA_W-1:0] old_sample;
	logic signed [SW-1:0]     sum_next;
	logic                     neg;
	logic        [SW-1:0]     mag;
	logic        [2*SW:0]     prod;
	logic        [DATA_W-1:0] quo;

	tcmma_ram #(
		.WIDTH (DATA_W),
		.DEPTH (WINDOW)
	) u_ring (
		.clk     (clk),
		.wr_en   (ctl.advance),
		.wr_addr (wr_addr),
		.wr_data (sample_s1),
		.rd_en   (ctl.accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			sample_s1 <= sample_in;
		end
	end

	// entries never written read as zero
	assign old_sample = ctl.old_valid ? $signed(rd_data) : '0;

	always_comb begin
		if (ctl.first) begin
			min_next = sample_s1;
			max_next = sample_s1;
		end else begin
			min_next = (sample_s1 < low_q)  ? sample_s1 : low_q;
			max_next = (sample_s1 > high_q) ? sample_s1 : high_q;
		end
	end

	assign sum_next = sum_q - SW'(old_sample) + SW'(sample_s1);

	// truncating division by the window through a reciprocal on the magnitude
	assign neg  = sum_next[SW-1];
	assign mag  = neg ? (~sum_next + 1'b1) : sum_next;
	assign prod = {{(SW+1){1'b0}}, mag} * {{SW{1'b0}}, RECIP};
	assign quo  = prod[K +: DATA_W];
	assign avg_next = neg ? $signed(~quo + 1'b1) : $signed(quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			sum_q  <= '0;
		end else if (ctl.advance) begin
			low_q  <= min_next;
			high_q <= max_next;
			sum_q  <= sum_next;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/three_channel_min_max_moving_average.sv
// top level of the three channel min/max moving average block
// depends on tcmma_pkg, tcmma_channel and tcmma_ram
`default_nettype none

// Takes one request per cycle while the output is not held by m_tready, carrying
// temperature, state of charge and charge rate samples (signed 16-bit, units of
// 1/64) and returns one result per request with the running minimum, maximum and
// boxcar average of each channel. A request is registered, then the extremes, the
// running sum and the average are formed combinationally and captured in the
// output register; the running sums and extremes are updated as each result is
// captured, and the next request needs this one's result. Each channel keeps its
// last WINDOW samples in a small ram read as the request is taken into the input
// register; slots not yet written since reset count as zero through per-slot
// valid flags, so no clearing pass is needed and the block accepts requests right
// after reset.
module three_channel_min_max_moving_average
	import tcmma_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// temperature_in, charge_state_in, charge_rate_in
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// temperature_min, temperature_max, temperature_avg, charge_state_min,
	// charge_state_max, charge_state_avg, charge_rate_min, charge_rate_max,
	// charge_rate_avg
	output logic      [OUT_W-1:0] m_tdata
);

	localparam int AW = $clog2(WINDOW);

	logic              valid_s1;
	logic [AW-1:0]     pos_s1;
	logic              old_valid_s1;
	logic [AW-1:0]     rd_pos_q;
	logic [WINDOW-1:0] slot_valid_q;
	logic              first_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic              accept;
	logic              advance;
	chan_ctl_t         ctl;

	logic signed [DATA_W-1:0] min_next [CHANNELS];
	logic signed [DATA_W-1:0] max_next [CHANNELS];
	logic signed [DATA_W-1:0] avg_next [CHANNELS];

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	assign ctl.accept    = accept;
	assign ctl.advance   = advance;
	assign ctl.first     = first_q;
	assign ctl.old_valid = old_valid_s1;

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
		tcmma_channel #(
			.WINDOW (WINDOW)
		) u_channel (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.rd_addr   (rd_pos_q),
			.wr_addr   (pos_s1),
			.sample_in ($signed(s_tdata[ch*DATA_W +: DATA_W])),
			.min_next  (min_next[ch]),
			.max_next  (max_next[ch]),
			.avg_next  (avg_next[ch])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1       <= rd_pos_q;
			old_valid_s1 <= slot_valid_q[rd_pos_q];
		end
		if (advance) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				out_data_q[(3*ch)*DATA_W   +: DATA_W] <= min_next[ch];
				out_data_q[(3*ch+1)*DATA_W +: DATA_W] <= max_next[ch];
				out_data_q[(3*ch+2)*DATA_W +: DATA_W] <= avg_next[ch];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rd_pos_q     <= '0;
			slot_valid_q <= '0;
			first_q      <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				rd_pos_q <= (rd_pos_q == AW'(WINDOW - 1)) ? '0 : rd_pos_q + 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				slot_valid_q[pos_s1] <= 1'b1;
				first_q              <= 1'b0;
				out_valid_q          <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// the ram is read one slot ahead of the request in the input register
	a_read_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> rd_pos_q == ((pos_s1 == AW'(WINDOW - 1)) ? '0 : pos_s1 + 1'b1))
		else $error("ring read position out of step");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q && !first_q)
		else $error("captured result not presented");

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chk
		a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
			out_valid_q |-> $signed(out_data_q[(3*ch)*DATA_W +: DATA_W])
				<= $signed(out_data_q[(3*ch+1)*DATA_W +: DATA_W]))
			else $error("minimum above maximum");
	end

endmodule

`default_nettype wire
